### design/gdfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gdfc_pkg;

  localparam int FIXED_W = 22;
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;

  localparam int NUM_STAGES = 13;

  localparam logic [YEAR_W-1:0]  MAX_YEAR  = 14'd9999;
  localparam logic [MONTH_W-1:0] MAX_MONTH = 4'd12;
  localparam logic [FIXED_W-1:0] MAX_FIXED = 22'd3652059;

  // Cycle lengths in days.
  localparam logic [17:0] DAYS_400 = 18'd146097;
  localparam logic [15:0] DAYS_100 = 16'd36524;
  localparam logic [10:0] DAYS_4   = 11'd1461;
  localparam logic [8:0]  DAYS_1   = 9'd365;

  // Reciprocal multipliers: q = (x * K) >> S.
  localparam logic [13:0] RECIP_100  = 14'd10486;  // shift 20, exact for 14-bit x
  localparam logic [4:0]  RECIP_400Y = 5'd28;      // shift 22, may be one low
  localparam logic [5:0]  RECIP_4Y   = 6'd44;      // shift 16, may be one low
  localparam logic [15:0] RECIP_367  = 16'd45715;  // shift 24, exact for 13-bit x

  localparam logic       FUNC_TO_FIXED = 1'b0;
  localparam logic       FUNC_TO_DATE  = 1'b1;

  typedef struct packed {
    logic                func;
    logic                err;
    logic [FIXED_W-1:0]  fixed;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic                leap;
    logic [YEAR_W-1:0]   p;        // year - 1
    logic [FIXED_W-1:0]  acc;      // running day count or remainder
    logic [7:0]          q100;
    logic [6:0]          r100;
    logic [4:0]          n400;
    logic [2:0]          n100;
    logic [4:0]          n4;
    logic [2:0]          n1;
    logic                special;  // last day of a 4- or 400-year cycle
    logic [8:0]          prior;    // days of this year before this day
  } stage_t;

  // Days before the first of the month, ignoring the leap correction.
  function automatic logic [8:0] month_term(input logic [MONTH_W-1:0] m);
    logic [8:0] t;
    case (m)
      4'd2:    t = 9'd31;
      4'd3:    t = 9'd61;
      4'd4:    t = 9'd92;
      4'd5:    t = 9'd122;
      4'd6:    t = 9'd153;
      4'd7:    t = 9'd183;
      4'd8:    t = 9'd214;
      4'd9:    t = 9'd245;
      4'd10:   t = 9'd275;
      4'd11:   t = 9'd306;
      4'd12:   t = 9'd336;
      default: t = 9'd0;
    endcase
    return t;
  endfunction

  // The month term assumes a 30-day February; take back 1 or 2 days after it.
  function automatic logic [1:0] month_adj(input logic [MONTH_W-1:0] m, input logic lp);
    logic [1:0] a;
    if (m <= 4'd2) begin
      a = 2'd0;
    end else if (lp) begin
      a = 2'd1;
    end else begin
      a = 2'd2;
    end
    return a;
  endfunction

endpackage

`default_nettype wire

### design/gdfc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gdfc_in_if;
  import gdfc_pkg::*;

  logic                valid;
  logic                ready;
  logic                func;
  logic [YEAR_W-1:0]   in_year;
  logic [MONTH_W-1:0]  in_month;
  logic [DAY_W-1:0]    in_day;
  logic [FIXED_W-1:0]  in_fixed;

  modport source (output valid, func, in_year, in_month, in_day, in_fixed, input ready);
  modport sink   (input valid, func, in_year, in_month, in_day, in_fixed, output ready);

endinterface

`default_nettype wire

### design/gdfc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gdfc_out_if;
  import gdfc_pkg::*;

  logic                valid;
  logic                ready;
  logic [FIXED_W-1:0]  out_fixed;
  logic [YEAR_W-1:0]   out_year;
  logic [MONTH_W-1:0]  out_month;
  logic [DAY_W-1:0]    out_day;
  logic                leap;
  logic                range_error;

  modport source (output valid, out_fixed, out_year, out_month, out_day, leap, range_error,
                  input ready);
  modport sink   (input valid, out_fixed, out_year, out_month, out_day, leap, range_error,
                  output ready);

endinterface

`default_nettype wire

### design/gregorian_date_fixed_convert_core.sv
// Gregorian date to fixed day count, and back; the direction is chosen per word.
// From input acceptance to a valid result, a word passes through one register per stage.
// Throughput: one word per cycle; each stage holds its word while the next is full.
// Reset clears only the stage valid bits; the data path holds no state.
`timescale 1ns / 1ps
`default_nettype none

module gregorian_date_fixed_convert_core (
  input wire logic    clk,
  input wire logic    rst,
  gdfc_in_if.sink     din,
  gdfc_out_if.source  dout
);
  import gdfc_pkg::*;

  stage_t entry;
  stage_t data  [NUM_STAGES];
  stage_t nxt   [NUM_STAGES-1];
  logic   vld   [NUM_STAGES];
  logic   rdy   [NUM_STAGES+1];

  always_comb begin
    entry       = '0;
    entry.func  = din.func;
    entry.fixed = din.in_fixed;
    entry.year  = din.in_year;
    entry.month = din.in_month;
    entry.day   = din.in_day;
    entry.p     = din.in_year - 14'd1;
    entry.acc   = din.in_fixed - 22'd1;
    if (din.func == FUNC_TO_FIXED) begin
      entry.err = (din.in_year == '0) || (din.in_year > MAX_YEAR) ||
                  (din.in_month == '0) || (din.in_month > MAX_MONTH) ||
                  (din.in_day == '0);
    end else begin
      entry.err = (din.in_fixed == '0) || (din.in_fixed > MAX_FIXED);
    end
  end

  gdfc_datapath u_datapath (
    .cur (data[0:NUM_STAGES-2]),
    .nxt (nxt)
  );

  assign rdy[NUM_STAGES] = dout.ready;

  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
    gdfc_stage u_stage (
      .clk        (clk),
      .rst        (rst),
      .in_valid   ((i == 0) ? din.valid : vld[(i == 0) ? 0 : i - 1]),
      .in_data    ((i == 0) ? entry : nxt[(i == 0) ? 0 : i - 1]),
      .ready_next (rdy[i+1]),
      .ready      (rdy[i]),
      .valid      (vld[i]),
      .data       (data[i])
    );
  end

  assign din.ready        = rdy[0];
  assign dout.valid       = vld[NUM_STAGES-1];
  assign dout.out_fixed   = data[NUM_STAGES-1].fixed;
  assign dout.out_year    = data[NUM_STAGES-1].year;
  assign dout.out_month   = data[NUM_STAGES-1].month;
  assign dout.out_day     = data[NUM_STAGES-1].day;
  assign dout.leap        = data[NUM_STAGES-1].leap;
  assign dout.range_error = data[NUM_STAGES-1].err;

endmodule

`default_nettype wire

### design/gdfc_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module gdfc_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire gdfc_pkg::stage_t in_data,
  input  wire logic             ready_next,
  output logic                  ready,
  output logic                  valid,
  output gdfc_pkg::stage_t      data
);
  import gdfc_pkg::*;

  // A stage takes a new word when it is empty or its word moves on.
  assign ready = !valid || ready_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      data <= in_data;
    end
  end

endmodule

`default_nettype wire

### design/gdfc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module gdfc_datapath (
  input  gdfc_pkg::stage_t cur [gdfc_pkg::NUM_STAGES-1],
  output gdfc_pkg::stage_t nxt [gdfc_pkg::NUM_STAGES-1]
);
  import gdfc_pkg::*;

  logic [27:0] prod100;
  logic [26:0] prod400;
  logic [21:0] prod4;
  logic [28:0] prod367;
  logic [9:0]  day_calc;
  logic [9:0]  leap_limit;
  logic [1:0]  corr;

  always_comb begin
    for (int i = 0; i < NUM_STAGES - 1; i++) begin
      nxt[i] = cur[i];
    end

    // Stage 1: reciprocal estimates of (year - 1) / 100 and of the 400-year count.
    prod100 = 28'(cur[0].p) * 28'(RECIP_100);
    prod400 = 27'(cur[0].acc) * 27'(RECIP_400Y);
    nxt[0].q100 = prod100[27:20];
    nxt[0].n400 = prod400[26:22];

    // Stage 2: century remainder, 365 days per prior year plus p/4, or the 400-year remainder.
    nxt[1].r100 = 7'(cur[1].p - 14'(cur[1].q100) * 14'd100);
    if (cur[1].func == FUNC_TO_FIXED) begin
      nxt[1].acc = 22'(cur[1].p) * 22'd365 + 22'(cur[1].p[13:2]);
    end else begin
      nxt[1].acc = cur[1].acc - 22'(cur[1].n400) * 22'(DAYS_400);
    end

    // Stage 3: leap flag, leap days of prior years and the day of month, or fix a low 400-year estimate.
    if (cur[2].func == FUNC_TO_FIXED) begin
      // Year is divisible by 4, and either not by 100 or also by 400.
      nxt[2].leap = (cur[2].p[1:0] == 2'd3) &&
                    ((cur[2].r100 != 7'd99) || (cur[2].q100[1:0] == 2'd3));
      nxt[2].acc  = cur[2].acc - 22'(cur[2].q100) + 22'(cur[2].q100[7:2]) +
                    22'(cur[2].day);
    end else if (cur[2].acc >= 22'(DAYS_400)) begin
      nxt[2].acc  = cur[2].acc - 22'(DAYS_400);
      nxt[2].n400 = cur[2].n400 + 5'd1;
    end

    // Stage 4: add the months, or split off whole centuries.
    if (cur[3].func == FUNC_TO_FIXED) begin
      nxt[3].fixed = cur[3].acc + 22'(month_term(cur[3].month)) -
                     22'(month_adj(cur[3].month, cur[3].leap));
    end else begin
      if (cur[3].acc >= 22'(4 * DAYS_100)) begin
        nxt[3].n100 = 3'd4;
      end else if (cur[3].acc >= 22'(3 * DAYS_100)) begin
        nxt[3].n100 = 3'd3;
      end else if (cur[3].acc >= 22'(2 * DAYS_100)) begin
        nxt[3].n100 = 3'd2;
      end else if (cur[3].acc >= 22'(DAYS_100)) begin
        nxt[3].n100 = 3'd1;
      end else begin
        nxt[3].n100 = 3'd0;
      end
      nxt[3].acc = cur[3].acc - 22'(nxt[3].n100) * 22'(DAYS_100);
    end

    // Stage 5: estimate of the 4-year count.
    prod4 = 22'(cur[4].acc[15:0]) * 22'(RECIP_4Y);
    if (cur[4].func == FUNC_TO_DATE) begin
      nxt[4].n4 = prod4[20:16];
    end

    // Stage 6: remainder against the estimate.
    if (cur[5].func == FUNC_TO_DATE) begin
      nxt[5].acc = 22'(cur[5].acc[15:0]) - 22'(cur[5].n4) * 22'(DAYS_4);
    end

    // Stage 7: fix a low 4-year estimate.
    if ((cur[6].func == FUNC_TO_DATE) && (cur[6].acc[11:0] >= 12'(DAYS_4))) begin
      nxt[6].acc = cur[6].acc - 22'(DAYS_4);
      nxt[6].n4  = cur[6].n4 + 5'd1;
    end

    // Stage 8: whole years inside the 4-year cycle.
    if (cur[7].func == FUNC_TO_DATE) begin
      if (cur[7].acc[10:0] >= 11'(4 * DAYS_1)) begin
        nxt[7].n1 = 3'd4;
      end else if (cur[7].acc[10:0] >= 11'(3 * DAYS_1)) begin
        nxt[7].n1 = 3'd3;
      end else if (cur[7].acc[10:0] >= 11'(2 * DAYS_1)) begin
        nxt[7].n1 = 3'd2;
      end else if (cur[7].acc[10:0] >= 11'(DAYS_1)) begin
        nxt[7].n1 = 3'd1;
      end else begin
        nxt[7].n1 = 3'd0;
      end
      nxt[7].acc     = 22'(cur[7].acc[10:0]) - 22'(nxt[7].n1) * 22'(DAYS_1);
      nxt[7].special = (cur[7].n100 == 3'd4) || (nxt[7].n1 == 3'd4);
    end

    // Stage 9: year, leap flag and day of year. The last day of a 4- or
    // 400-year cycle is 31 December of a leap year.
    if (cur[8].func == FUNC_TO_DATE) begin
      nxt[8].year  = 14'(cur[8].n400) * 14'd400 + 14'(cur[8].n100) * 14'd100 +
                     {7'd0, cur[8].n4, 2'd0} + 14'(cur[8].n1) + 14'(!cur[8].special);
      nxt[8].leap  = cur[8].special ||
                     ((cur[8].n1 == 3'd3) && ((cur[8].n4 != 5'd24) || (cur[8].n100 == 3'd3)));
      nxt[8].prior = cur[8].special ? DAYS_1 : cur[8].acc[8:0];
    end

    // Stage 10: month numerator.
    leap_limit = 10'd59 + 10'(cur[9].leap);
    if (10'(cur[9].prior) < leap_limit) begin
      corr = 2'd0;
    end else if (cur[9].leap) begin
      corr = 2'd1;
    end else begin
      corr = 2'd2;
    end
    if (cur[9].func == FUNC_TO_DATE) begin
      nxt[9].acc = 22'(13'd12 * (13'(cur[9].prior) + 13'(corr)) + 13'd373);
    end

    // Stage 11: month as numerator / 367.
    prod367 = 29'(cur[10].acc[12:0]) * 29'(RECIP_367);
    if (cur[10].func == FUNC_TO_DATE) begin
      nxt[10].month = prod367[27:24];
    end

    // Stage 12: day of month, and zero the date, fixed count and leap flag on a range error.
    day_calc = 10'(cur[11].prior) + 10'(month_adj(cur[11].month, cur[11].leap)) + 10'd1 -
               10'(month_term(cur[11].month));
    if (cur[11].func == FUNC_TO_DATE) begin
      nxt[11].day = day_calc[4:0];
    end
    if (cur[11].err) begin
      nxt[11].fixed = '0;
      nxt[11].year  = '0;
      nxt[11].month = '0;
      nxt[11].day   = '0;
      nxt[11].leap  = 1'b0;
    end
  end

endmodule

`default_nettype wire
